// File: hw/rtl/iatp_pkg.sv
// Package for the IP address text parser: item structs, token kinds,
// status and family codes, character codes and queue depths.
// No dependencies; imported by the front, back and top modules.
package iatp_pkg;

  localparam int MID_DEPTH  = 2;
  localparam int OUT_DEPTH  = 2;
  localparam int NUM_GROUPS = 8;

  localparam logic [1:0] FAM_V4 = 2'd0;
  localparam logic [1:0] FAM_V6 = 2'd1;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_MALFORMED   = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  localparam logic [15:0] V4_GROUP_MAX = 16'd255;
  localparam logic [2:0]  V4_DIGITS_BAD = 3'd4;
  localparam logic [2:0]  V6_DIGITS_BAD = 3'd5;
  localparam logic [3:0]  V4_GROUPS_MAX = 4'd4;
  localparam logic [3:0]  V4_DOTS_OK    = 4'd3;

  typedef enum logic [2:0] {
    K_DIGIT,
    K_DOT,
    K_COLON,
    K_END,
    K_BAD
  } kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [1:0] family;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } out_item_t;

  // classified character, as passed from front to back
  typedef struct packed {
    kind_t      kind;
    logic [3:0] digit;
    logic [1:0] family;
  } tok_t;

endpackage

// File: hw/rtl/iatp_fifo.sv
// Small register queue with show-ahead read, used between the front and
// back parts and on the result side. Depends on nothing.
module iatp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count above depth");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> !empty)
    else $error("queue empty after a transfer in");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop && !do_push |=> !full)
    else $error("queue full after a transfer out");

endmodule

// File: hw/rtl/iatp_front.sv
// Front part: latches the family at each string's first character and
// classifies every character into a token. Depends on iatp_pkg.
module iatp_front
  import iatp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  output logic     tok_push,
  output tok_t     tok,
  input  logic     tok_full
);

  logic       at_start_r, at_start_nxt;
  logic [1:0] fam_r, fam_nxt;
  logic       accept;

  assign full     = tok_full;
  assign accept   = push && !tok_full;
  assign tok_push = accept;

  always_comb begin
    fam_nxt      = at_start_r ? in_item.family : fam_r;
    at_start_nxt = at_start_r;
    if (accept) begin
      at_start_nxt = (in_item.ch == CH_NUL);
    end

    tok.family = fam_nxt;
    tok.digit  = '0;
    tok.kind   = K_BAD;
    if (in_item.ch == CH_NUL) begin
      tok.kind = K_END;
    end else begin
      unique case (fam_nxt)
        FAM_V4: begin
          if (in_item.ch >= CH_0 && in_item.ch <= CH_9) begin
            tok.kind  = K_DIGIT;
            tok.digit = 4'(in_item.ch - CH_0);
          end else if (in_item.ch == CH_DOT) begin
            tok.kind = K_DOT;
          end
        end
        FAM_V6: begin
          if (in_item.ch >= CH_0 && in_item.ch <= CH_9) begin
            tok.kind  = K_DIGIT;
            tok.digit = 4'(in_item.ch - CH_0);
          end else if (in_item.ch >= CH_LA && in_item.ch <= CH_LF) begin
            tok.kind  = K_DIGIT;
            tok.digit = 4'(in_item.ch - CH_LA + 8'd10);
          end else if (in_item.ch >= CH_UA && in_item.ch <= CH_UF) begin
            tok.kind  = K_DIGIT;
            tok.digit = 4'(in_item.ch - CH_UA + 8'd10);
          end else if (in_item.ch == CH_COLON) begin
            tok.kind = K_COLON;
          end
        end
        default: tok.kind = K_BAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r <= 1'b1;
      fam_r      <= FAM_V4;
    end else if (accept) begin
      at_start_r <= at_start_nxt;
      fam_r      <= fam_nxt;
    end
  end

endmodule

// File: hw/rtl/iatp_back.sv
// Back part: runs the group parser on tokens, keeps the group stores and
// builds the status and 128-bit address at each string end.
// Depends on iatp_pkg.
module iatp_back
  import iatp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  tok_t      tok,
  input  logic      tok_empty,
  output logic      tok_pop,
  input  logic      res_full,
  output logic      res_push,
  output out_item_t res
);

  logic        failed_r, failed_nxt;
  logic [2:0]  dcnt_r, dcnt_nxt;
  logic [15:0] gval_r, gval_nxt;
  logic [3:0]  fcnt_r, fcnt_nxt;
  logic [3:0]  bcnt_r, bcnt_nxt;
  logic        gap_r, gap_nxt;
  logic [15:0] front_grp_r [NUM_GROUPS];
  logic [15:0] back_grp_r [NUM_GROUPS];
  logic        fw_en, bw_en;
  logic [2:0]  dcnt_inc;
  logic [4:0]  grp_sum;

  logic [3:0]  fc2, bc2;
  logic [4:0]  spos;
  logic [2:0]  k;
  logic [15:0] g [NUM_GROUPS];

  assign tok_pop  = !tok_empty && (tok.kind != K_END || !res_full);
  assign res_push = tok_pop && (tok.kind == K_END);
  assign dcnt_inc = dcnt_r + 3'd1;
  assign grp_sum  = {1'b0, fcnt_r} + {1'b0, bcnt_r};

  always_comb begin
    failed_nxt = failed_r;
    dcnt_nxt   = dcnt_r;
    gval_nxt   = gval_r;
    fcnt_nxt   = fcnt_r;
    bcnt_nxt   = bcnt_r;
    gap_nxt    = gap_r;
    fw_en      = 1'b0;
    bw_en      = 1'b0;
    if (tok_pop) begin
      if (tok.kind == K_END) begin
        failed_nxt = 1'b0;
        dcnt_nxt   = '0;
        gval_nxt   = '0;
        fcnt_nxt   = '0;
        bcnt_nxt   = '0;
        gap_nxt    = 1'b0;
      end else if (!failed_r) begin
        unique case (tok.family)
          FAM_V4: begin
            unique case (tok.kind)
              K_DOT: begin
                if (fcnt_r >= V4_GROUPS_MAX || dcnt_r == '0 || gval_r > V4_GROUP_MAX) begin
                  failed_nxt = 1'b1;
                end else begin
                  fw_en    = 1'b1;
                  fcnt_nxt = fcnt_r + 4'd1;
                  dcnt_nxt = '0;
                  gval_nxt = '0;
                end
              end
              K_DIGIT: begin
                gval_nxt = (gval_r << 3) + (gval_r << 1) + {12'b0, tok.digit};
                dcnt_nxt = dcnt_inc;
                if (dcnt_inc >= V4_DIGITS_BAD) failed_nxt = 1'b1;
              end
              default: failed_nxt = 1'b1;
            endcase
          end
          FAM_V6: begin
            unique case (tok.kind)
              K_COLON: begin
                if (grp_sum >= 5'(NUM_GROUPS)) begin
                  failed_nxt = 1'b1;
                end else if (dcnt_r == '0) begin
                  // an empty group opens the right-aligned part
                  if (gap_r && bcnt_r > 4'd1) failed_nxt = 1'b1;
                  else gap_nxt = 1'b1;
                end else begin
                  if (!gap_r) begin
                    fw_en    = 1'b1;
                    fcnt_nxt = fcnt_r + 4'd1;
                  end else begin
                    bw_en    = 1'b1;
                    bcnt_nxt = bcnt_r + 4'd1;
                  end
                  dcnt_nxt = '0;
                  gval_nxt = '0;
                end
              end
              K_DIGIT: begin
                gval_nxt = {gval_r[11:0], tok.digit};
                dcnt_nxt = dcnt_inc;
                if (dcnt_inc >= V6_DIGITS_BAD) failed_nxt = 1'b1;
              end
              default: failed_nxt = 1'b1;
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  // result for the string that ends with the current token
  always_comb begin
    fc2  = fcnt_r + {3'b0, !gap_r};
    bc2  = bcnt_r + {3'b0, gap_r};
    spos = '0;
    k    = '0;
    for (int i = 0; i < NUM_GROUPS; i++) begin
      g[i] = '0;
      if (4'(i) < fcnt_r) begin
        g[i] = front_grp_r[i];
      end else if (!gap_r && 4'(i) == fcnt_r) begin
        g[i] = gval_r;
      end
      spos = 5'(i) + {1'b0, bc2};
      if (spos >= 5'(NUM_GROUPS)) begin
        k = spos[2:0];
        if ({1'b0, k} < bcnt_r) g[i] = back_grp_r[k];
        else if (gap_r) g[i] = gval_r;
      end
    end

    res.status    = ST_OK;
    res.addr_high = '0;
    res.addr_low  = '0;
    if (tok.family != FAM_V4 && tok.family != FAM_V6) begin
      res.status = ST_UNSUPPORTED;
    end else if (failed_r) begin
      res.status = ST_MALFORMED;
    end else if (tok.family == FAM_V4) begin
      if (dcnt_r == '0 || gval_r > V4_GROUP_MAX || fcnt_r != V4_DOTS_OK) begin
        res.status = ST_MALFORMED;
      end else begin
        res.addr_low = {32'b0, front_grp_r[0][7:0], front_grp_r[1][7:0],
                        front_grp_r[2][7:0], gval_r[7:0]};
      end
    end else if (grp_sum >= 5'(NUM_GROUPS)) begin
      res.status = ST_MALFORMED;
    end else if (fc2 <= 4'd1 && bc2 == '0) begin
      // a lone group with no gap is too short
      res.status = ST_MALFORMED;
    end else begin
      res.addr_high = {g[0], g[1], g[2], g[3]};
      res.addr_low  = {g[4], g[5], g[6], g[7]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      failed_r <= 1'b0;
      dcnt_r   <= '0;
      gval_r   <= '0;
      fcnt_r   <= '0;
      bcnt_r   <= '0;
      gap_r    <= 1'b0;
    end else begin
      failed_r <= failed_nxt;
      dcnt_r   <= dcnt_nxt;
      gval_r   <= gval_nxt;
      fcnt_r   <= fcnt_nxt;
      bcnt_r   <= bcnt_nxt;
      gap_r    <= gap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fw_en) front_grp_r[fcnt_r[2:0]] <= gval_r;
    if (bw_en) back_grp_r[bcnt_r[2:0]] <= gval_r;
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result written while result queue full");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> (fcnt_r == '0 && bcnt_r == '0 && !failed_r && !gap_r))
    else $error("string state not cleared after end");

  a_group_bound: assert property (@(posedge clk) disable iff (!rst_n)
    grp_sum <= 5'(NUM_GROUPS))
    else $error("group count above eight");

  a_v4_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && tok.family == FAM_V4 |-> res.addr_high == '0)
    else $error("IPv4 result with upper half set");

endmodule

// File: hw/rtl/ip_address_text_parser_unit.sv
// IP address text parser: a character-by-character parser for IPv4 and
// IPv6 address text. Top level; depends on iatp_pkg, iatp_front,
// iatp_back and iatp_fifo.
//
// Input queue side: one character and a family code per transfer (push
// while full is low). The family is taken from each string's first
// character; a zero character ends the string.
// Result queue side: one status plus 128-bit address per string, shown
// while empty is low and taken with pop. Other characters give no result.
// Throughput: one character per cycle, set by the parse step in the back part;
// a terminating character waits while the result queue is full. A result
// shows on the result ports once its terminating character has passed the
// token queue and the back part has written the result queue; pop takes it.
// Reset clears both queues and the parser state; the group stores are not
// cleared and need no clearing pass.
// When the receiver stalls, the result queue holds two results; the back
// part then holds a terminating character, the token queue fills and full
// rises. Characters that end no string keep flowing until the next end.
module ip_address_text_parser_unit
  import iatp_pkg::*;
#(
  parameter int MidDepth = MID_DEPTH,
  parameter int OutDepth = OUT_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item
);

  localparam int TOK_W = $bits(tok_t);
  localparam int RES_W = $bits(out_item_t);

  logic             tok_push, tok_full, tok_pop, tok_empty;
  tok_t             tok_in, tok_out;
  logic [TOK_W-1:0] tok_rd;
  logic             res_push, res_full;
  out_item_t        res_in;
  logic [RES_W-1:0] res_rd;

  iatp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .tok_push (tok_push),
    .tok      (tok_in),
    .tok_full (tok_full)
  );

  iatp_fifo #(
    .WIDTH (TOK_W),
    .DEPTH (MidDepth)
  ) u_tok_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (tok_push),
    .wr_data (tok_in),
    .full    (tok_full),
    .pop     (tok_pop),
    .rd_data (tok_rd),
    .empty   (tok_empty)
  );

  assign tok_out = tok_t'(tok_rd);

  iatp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok       (tok_out),
    .tok_empty (tok_empty),
    .tok_pop   (tok_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  iatp_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OutDepth)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .pop     (pop),
    .rd_data (res_rd),
    .empty   (empty)
  );

  assign out_item = out_item_t'(res_rd);

endmodule
